@@ hdl/mrk4_pkg.sv @@
// Shared types, constants and fixed-point helpers of the RK4 muscle model pipeline.
package mrk4_pkg;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = 32'sh7FFFFFFF;
	localparam q_t Q_MIN = 32'sh80000000;

	localparam logic [2:0] REG_STEP    = 3'd0;
	localparam logic [2:0] REG_GOAL    = 3'd1;
	localparam logic [2:0] REG_STIFF   = 3'd2;
	localparam logic [2:0] REG_DAMP    = 3'd3;
	localparam logic [2:0] REG_MASS    = 3'd4;
	localparam logic [2:0] REG_LENGTH  = 3'd5;
	localparam logic [2:0] REG_GRAVITY = 3'd6;
	localparam logic [2:0] REG_TSCALE  = 3'd7;

	localparam int ACC_LAT  = 16;
	localparam int GLUE_LAT = 3;
	localparam int FIN_LAT  = 2;
	localparam int SUB_LAT  = 4 * ACC_LAT + GLUE_LAT + FIN_LAT;

	localparam logic [33:0] TWO_PI34 = 34'd411775;
	localparam logic [33:0] ANG_OFS  = 34'd4295225025;
	localparam logic signed [19:0] TWO_PI_Q  = 20'sd411775;
	localparam logic signed [19:0] PI_Q      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q = 20'sd102944;
	localparam logic signed [19:0] COR_GAIN  = 20'sd39797;
	localparam logic signed [19:0] ONE_Q20   = 20'sd65536;

	typedef struct packed {
		q_t y;
		q_t z;
		q_t torque;
		q_t k1y;
		q_t k2z;
		q_t k2y;
		q_t k3z;
		q_t k3y;
		q_t k4z;
	} sb_t;

	typedef struct packed {
		q_t          goal;
		logic [30:0] stiff;
		logic [30:0] damp;
		logic [30:0] inertia;
		q_t          gl;
	} cfg_t;

	typedef struct packed {
		logic [47:0] num;
		logic [30:0] rem;
		logic [31:0] quo;
		logic        ovf;
		logic        neg;
		logic        nz;
	} div_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
	} cor_t;

	typedef struct packed {
		sb_t         sb;
		div_t        dk;
		div_t        dd;
		logic [33:0] u;
		cor_t        c;
	} astage_t;

	function automatic q_t sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return Q_MAX;
		if (v < -64'sd2147483648) return Q_MIN;
		return $signed(v[31:0]);
	endfunction

	function automatic q_t sat35(input logic signed [34:0] v);
		if (v > 35'sd2147483647) return Q_MAX;
		if (v < -35'sd2147483648) return Q_MIN;
		return $signed(v[31:0]);
	endfunction

	function automatic q_t mulq(input q_t a, input q_t b);
		logic signed [63:0] p;
		p = a * b;
		return sat64(p >>> 16);
	endfunction

	function automatic q_t add_sat(input q_t a, input q_t b);
		return sat35(35'(a) + 35'(b));
	endfunction

	function automatic q_t neg_sat(input q_t a);
		return (a == Q_MIN) ? Q_MAX : -a;
	endfunction

	function automatic div_t div_init(input q_t a);
		div_t d;
		logic [31:0] ua;
		ua = a;
		d.neg = ua[31];
		d.nz = (ua != 32'd0);
		d.num = {(ua[31] ? (~ua + 32'd1) : ua), 16'd0};
		d.rem = '0;
		d.quo = '0;
		d.ovf = 1'b0;
		return d;
	endfunction

	function automatic div_t div_step4(input div_t d, input logic [30:0] b);
		div_t r;
		logic [31:0] ext;
		r = d;
		for (int j = 0; j < 4; j++) begin
			ext = {r.rem, r.num[47]};
			r.num = {r.num[46:0], 1'b0};
			r.ovf = r.ovf | r.quo[31];
			if (ext >= {1'b0, b}) begin
				ext = ext - {1'b0, b};
				r.quo = {r.quo[30:0], 1'b1};
			end else begin
				r.quo = {r.quo[30:0], 1'b0};
			end
			r.rem = ext[30:0];
		end
		return r;
	endfunction

	function automatic q_t div_final(input div_t d);
		if (!d.nz) return '0;
		if (d.ovf) return d.neg ? Q_MIN : Q_MAX;
		if (!d.neg) return d.quo[31] ? Q_MAX : $signed(d.quo);
		if (d.quo > 32'h80000000) return Q_MIN;
		return $signed(~d.quo + 32'd1);
	endfunction

	function automatic logic [33:0] red5(input logic [33:0] u, input int hi);
		logic [33:0] r;
		r = u;
		for (int j = 0; j < 5; j++) begin
			if (r >= (TWO_PI34 << (hi - j))) r = r - (TWO_PI34 << (hi - j));
		end
		return r;
	endfunction

	function automatic logic signed [19:0] fold(input logic [33:0] u);
		logic signed [19:0] r;
		r = $signed({1'b0, u[18:0]});
		if (r > PI_Q) r = r - TWO_PI_Q;
		if (r > HALF_PI_Q) r = PI_Q - r;
		else if (r < -HALF_PI_Q) r = -PI_Q - r;
		return r;
	endfunction

	function automatic logic signed [19:0] atan_q(input int i);
		case (i)
			0:       return 20'sd51472;
			1:       return 20'sd30386;
			2:       return 20'sd16055;
			3:       return 20'sd8150;
			4:       return 20'sd4091;
			5:       return 20'sd2047;
			6:       return 20'sd1024;
			7:       return 20'sd512;
			8:       return 20'sd256;
			9:       return 20'sd128;
			10:      return 20'sd64;
			11:      return 20'sd32;
			12:      return 20'sd16;
			13:      return 20'sd8;
			14:      return 20'sd4;
			15:      return 20'sd2;
			default: return '0;
		endcase
	endfunction

	function automatic cor_t cor_init(input logic signed [19:0] ang);
		cor_t c;
		c.x = COR_GAIN;
		c.y = '0;
		c.z = ang;
		return c;
	endfunction

	function automatic cor_t cor_step4(input cor_t c, input int base);
		cor_t r;
		logic signed [19:0] dx;
		logic signed [19:0] dy;
		r = c;
		for (int j = 0; j < 4; j++) begin
			dx = r.y >>> (base + j);
			dy = r.x >>> (base + j);
			if (r.z >= 0) begin
				r.x = r.x - dx;
				r.y = r.y + dy;
				r.z = r.z - atan_q(base + j);
			end else begin
				r.x = r.x + dx;
				r.y = r.y - dy;
				r.z = r.z + atan_q(base + j);
			end
		end
		return r;
	endfunction

	function automatic q_t cor_clamp(input logic signed [19:0] y);
		if (y > ONE_Q20) return 32'sd65536;
		if (y < -ONE_Q20) return -32'sd65536;
		return 32'(y);
	endfunction

endpackage

@@ hdl/muscle_model_rk4_step.sv @@
// Throughput one item per cycle.
// Each substep chains four 16-stage acceleration units, each holding two 12-stage
// radix-16 dividers and a CORDIC sine, joined by three update stages and followed by two sum stages.
// Reset clears the valid bits and loads the configuration registers with their defaults.
// The receiver cannot stall, so busy stays low and every result shows for one cycle.
module muscle_model_rk4_step import mrk4_pkg::*; #(
	parameter int SUBSTEPS = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  q_t          position,
	input  q_t          velocity,
	input  q_t          external_torque,
	output logic        done,
	output q_t          new_position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int LAT = 1 + SUBSTEPS * SUB_LAT;

	logic [30:0] step_size_q;
	q_t          goal_position_q;
	logic [30:0] stiffness_q;
	logic [30:0] damping_q;
	logic [30:0] mass_q;
	logic [30:0] arm_length_q;
	logic [30:0] gravity_q;
	q_t          torque_scale_q;
	logic [28:0] h6_q;
	q_t          ml_q;
	logic [30:0] inertia_q;
	q_t          gl_q;
	q_t          inertia_full;
	logic [62:0] h6_prod;
	div_t        gl_s [1:13];
	cfg_t        acfg;
	q_t          hhq;
	q_t          hq;
	q_t          h6q;
	logic        ent_vld_s0;
	sb_t         ent_sb_s0;
	sb_t         ent_nxt;
	logic        chain_vld [0:SUBSTEPS];
	sb_t         chain_sb [0:SUBSTEPS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q     <= 31'd655;
			goal_position_q <= '0;
			stiffness_q     <= '0;
			damping_q       <= '0;
			mass_q          <= 31'd65536;
			arm_length_q    <= 31'd65536;
			gravity_q       <= 31'd642252;
			torque_scale_q  <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP:    step_size_q     <= cfg_data[30:0];
				REG_GOAL:    goal_position_q <= $signed(cfg_data);
				REG_STIFF:   stiffness_q     <= cfg_data[30:0];
				REG_DAMP:    damping_q       <= cfg_data[30:0];
				REG_MASS:    mass_q          <= cfg_data[30:0];
				REG_LENGTH:  arm_length_q    <= cfg_data[30:0];
				REG_GRAVITY: gravity_q       <= cfg_data[30:0];
				REG_TSCALE:  torque_scale_q  <= $signed(cfg_data);
			endcase
		end
	end

	assign h6_prod      = 63'(step_size_q) * 63'(32'hAAAAAAAB);
	assign inertia_full = mulq(ml_q, $signed({1'b0, arm_length_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h6_q      <= 29'd109;
			ml_q      <= 32'sd65536;
			inertia_q <= 31'd65536;
		end else begin
			h6_q      <= h6_prod[62:34];
			ml_q      <= mulq($signed({1'b0, mass_q}), $signed({1'b0, arm_length_q}));
			inertia_q <= inertia_full[30:0];
		end
	end

	always_ff @(posedge clk) begin
		gl_s[1] <= div_init($signed({1'b0, gravity_q}));
		gl_q    <= div_final(gl_s[13]);
	end

	for (genvar j = 2; j <= 13; j++) begin : g_gl
		always_ff @(posedge clk) begin
			gl_s[j] <= div_step4(gl_s[j-1], arm_length_q);
		end
	end

	always_comb begin
		acfg.goal    = goal_position_q;
		acfg.stiff   = stiffness_q;
		acfg.damp    = damping_q;
		acfg.inertia = inertia_q;
		acfg.gl      = gl_q;
	end

	assign hhq = $signed({2'b0, step_size_q[30:1]});
	assign hq  = $signed({1'b0, step_size_q});
	assign h6q = $signed({3'b0, h6_q});

	always_comb begin
		ent_nxt = '0;
		ent_nxt.y = position;
		ent_nxt.z = velocity;
		ent_nxt.torque = mulq(external_torque, torque_scale_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_s0 <= 1'b0;
		end else begin
			ent_vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ent_sb_s0 <= ent_nxt;
	end

	assign chain_vld[0] = ent_vld_s0;
	assign chain_sb[0]  = ent_sb_s0;

	for (genvar n = 0; n < SUBSTEPS; n++) begin : g_sub
		logic       a_in_vld [4];
		q_t         a_in_pos [4];
		q_t         a_in_vel [4];
		sb_t        a_in_side [4];
		logic       a_vld [4];
		q_t         a_res [4];
		sb_t        a_side [4];
		logic [2:0] gv_s;
		q_t         gpos_s [3];
		q_t         gvel_s [3];
		sb_t        gside_s [3];
		logic       f1_vld_s;
		sb_t        f1_sb_s;
		q_t         sy_s;
		q_t         sz_s;
		logic       f2_vld_s;
		sb_t        f2_sb_s;
		sb_t        f2_nxt;

		for (genvar k = 0; k < 4; k++) begin : g_acc
			if (k == 0) begin : g_first
				assign a_in_vld[k]  = chain_vld[n];
				assign a_in_pos[k]  = chain_sb[n].y;
				assign a_in_vel[k]  = chain_sb[n].z;
				assign a_in_side[k] = chain_sb[n];
			end else begin : g_next
				assign a_in_vld[k]  = gv_s[k-1];
				assign a_in_pos[k]  = gpos_s[k-1];
				assign a_in_vel[k]  = gvel_s[k-1];
				assign a_in_side[k] = gside_s[k-1];
			end

			mrk4_accel u_accel (
				.clk      (clk),
				.arst_n   (arst_n),
				.vld      (a_in_vld[k]),
				.pos      (a_in_pos[k]),
				.vel      (a_in_vel[k]),
				.side     (a_in_side[k]),
				.cfg      (acfg),
				.res_vld  (a_vld[k]),
				.accel    (a_res[k]),
				.res_side (a_side[k])
			);
		end

		for (genvar k = 0; k < 3; k++) begin : g_glue
			sb_t g_side;
			q_t  g_pos;
			always_comb begin
				g_side = a_side[k];
				g_pos  = '0;
				if (k == 0) begin
					g_side.k1y = a_res[k];
					g_side.k2z = add_sat(g_side.z, mulq(a_res[k], hhq));
					g_pos      = add_sat(g_side.y, mulq(g_side.z, hhq));
				end else if (k == 1) begin
					g_side.k2y = a_res[k];
					g_side.k3z = add_sat(g_side.z, mulq(a_res[k], hhq));
					g_pos      = add_sat(g_side.y, mulq(g_side.k2z, hhq));
				end else begin
					g_side.k3y = a_res[k];
					g_side.k4z = add_sat(g_side.z, mulq(a_res[k], hq));
					g_pos      = add_sat(g_side.y, mulq(g_side.k3z, hq));
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					gv_s[k] <= 1'b0;
				end else begin
					gv_s[k] <= a_vld[k];
				end
			end

			always_ff @(posedge clk) begin
				gside_s[k] <= g_side;
				gpos_s[k]  <= g_pos;
				gvel_s[k]  <= (k == 0) ? g_side.k2z : ((k == 1) ? g_side.k3z : g_side.k4z);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				f1_vld_s <= 1'b0;
				f2_vld_s <= 1'b0;
			end else begin
				f1_vld_s <= a_vld[3];
				f2_vld_s <= f1_vld_s;
			end
		end

		always_comb begin
			f2_nxt = f1_sb_s;
			f2_nxt.y = add_sat(f1_sb_s.y, mulq(h6q, sy_s));
			f2_nxt.z = add_sat(f1_sb_s.z, mulq(h6q, sz_s));
		end

		always_ff @(posedge clk) begin
			f1_sb_s <= a_side[3];
			sy_s    <= sat35(35'(a_side[3].z) + (35'(a_side[3].k2z) <<< 1)
				+ (35'(a_side[3].k3z) <<< 1) + 35'(a_side[3].k4z));
			sz_s    <= sat35(35'(a_side[3].k1y) + (35'(a_side[3].k2y) <<< 1)
				+ (35'(a_side[3].k3y) <<< 1) + 35'(a_res[3]));
			f2_sb_s <= f2_nxt;
		end

		assign chain_vld[n+1] = f2_vld_s;
		assign chain_sb[n+1]  = f2_sb_s;
	end

	assign done         = chain_vld[SUBSTEPS];
	assign new_position = chain_sb[SUBSTEPS].y;

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted transaction");

	a_h6_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(step_size_q) |-> ((35'(h6_q) * 35'd6 <= 35'(step_size_q))
			&& (35'(step_size_q) < 35'(h6_q) * 35'd6 + 35'd6)))
		else $error("step/6 weight out of range");

	a_goal_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_GOAL)
			|=> (goal_position_q == $signed($past(cfg_data))))
		else $error("goal write transaction not applied");
`endif

endmodule

@@ hdl/mrk4_accel.sv @@
// Sixteen-stage pipelined acceleration unit: spring, damper, gravity and torque terms.
module mrk4_accel import mrk4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vld,
	input  q_t   pos,
	input  q_t   vel,
	input  sb_t  side,
	input  cfg_t cfg,
	output logic res_vld,
	output q_t   accel,
	output sb_t  res_side
);

	logic [ACC_LAT-1:0] vld_s;
	q_t          pk_s0;
	q_t          pd_s0;
	logic [33:0] u_s0;
	sb_t         sb_s0;
	astage_t     pipe_s [1:13];
	astage_t     s1_nxt;
	q_t          tk_s14;
	q_t          td_s14;
	q_t          gr_s14;
	sb_t         sb_s14;
	q_t          acc_s15;
	sb_t         sb_s15;
	logic signed [33:0] ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ACC_LAT-2:0], vld};
		end
	end

	assign ang = 34'(pos) - 34'(cfg.goal);

	always_ff @(posedge clk) begin
		pk_s0 <= mulq(sat35(35'(cfg.goal) - 35'(pos)), $signed({1'b0, cfg.stiff}));
		pd_s0 <= mulq(vel, $signed({1'b0, cfg.damp}));
		u_s0  <= $unsigned(ang) + ANG_OFS;
		sb_s0 <= side;
	end

	always_comb begin
		s1_nxt = '0;
		s1_nxt.sb = sb_s0;
		s1_nxt.dk = div_init(pk_s0);
		s1_nxt.dd = div_init(pd_s0);
		s1_nxt.u = red5(u_s0, 14);
	end

	always_ff @(posedge clk) begin
		pipe_s[1] <= s1_nxt;
	end

	for (genvar j = 2; j <= 13; j++) begin : g_st
		astage_t nxt;
		always_comb begin
			nxt = pipe_s[j-1];
			nxt.dk = div_step4(pipe_s[j-1].dk, cfg.inertia);
			nxt.dd = div_step4(pipe_s[j-1].dd, cfg.inertia);
			if (j == 2) begin
				nxt.u = red5(pipe_s[j-1].u, 9);
			end else if (j == 3) begin
				nxt.u = red5(pipe_s[j-1].u, 4);
			end else if (j == 4) begin
				nxt.c = cor_init(fold(pipe_s[j-1].u));
			end else if (j >= 5 && j <= 8) begin
				nxt.c = cor_step4(pipe_s[j-1].c, (j - 5) * 4);
			end
		end
		always_ff @(posedge clk) begin
			pipe_s[j] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		tk_s14  <= div_final(pipe_s[13].dk);
		td_s14  <= neg_sat(div_final(pipe_s[13].dd));
		gr_s14  <= mulq(cfg.gl, cor_clamp(pipe_s[13].c.y));
		sb_s14  <= pipe_s[13].sb;
		acc_s15 <= sat35(-35'(gr_s14) - 35'(sb_s14.torque) + 35'(tk_s14) + 35'(td_s14));
		sb_s15  <= sb_s14;
	end

	assign res_vld  = vld_s[ACC_LAT-1];
	assign accel    = acc_s15;
	assign res_side = sb_s15;

endmodule
